### hw/rtl/gbe_pkg.sv
// ----------------------------------------------------------------------------
// gbe_pkg
// Shared types and constants for the glyph bitmap embolden block: beat
// payloads, register indexes and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package gbe_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int PIX_W      = 8;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HORIZ_STRENGTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VERT_STRENGTH  = 2'd3;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

    typedef struct packed {
        logic             kind;
        logic [PIX_W-1:0] pixel_in;
    } t_in_beat;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_last;
    } t_out_beat;

    typedef struct packed {
        logic start_pix;
        logic start_flush;
        logic widen;
        logic rd_issue;
        logic wr_line;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic in_full;
        logic have;
        logic vs_zero;
        logic rd_last;
        logic out_free;
    } t_status;

endpackage

### hw/rtl/gbe_ram.sv
// ----------------------------------------------------------------------------
// gbe_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module gbe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/gbe_ctrl.sv
// ----------------------------------------------------------------------------
// gbe_ctrl
// Sequencer for the embolden block: accepts a beat, steps the datapath
// through widening, line store reads, line store write and result hand-off (a flush beat only reads and hands off).
// ----------------------------------------------------------------------------
module gbe_ctrl
    import gbe_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_kind,
    output logic    o_in_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_WIDEN = 6'b000010,
        S_READ  = 6'b000100,
        S_DRAIN = 6'b001000,
        S_WRITE = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_flush, n_flush;
    logic   r_have, n_have;

    always_comb begin
        n_state = r_state;
        n_flush = r_flush;
        n_have  = r_have;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_kind == KIND_PIXEL) begin
                        if (!i_status.in_full) begin
                            o_cmd.start_pix = 1'b1;
                            n_flush         = 1'b0;
                            n_state         = S_WIDEN;
                        end
                    end else if (i_status.in_full) begin
                        o_cmd.start_flush = 1'b1;
                        n_flush           = 1'b1;
                        n_state           = S_READ;
                    end
                end
            end
            S_WIDEN: begin
                o_cmd.widen = 1'b1;
                n_have      = i_status.have;
                if (i_status.have && !i_status.vs_zero) begin
                    n_state = S_READ;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                if (i_status.rd_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = r_flush ? S_EMIT : S_WRITE;
            end
            S_WRITE: begin
                o_cmd.wr_line = 1'b1;
                n_state       = r_have ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_flush <= 1'b0;
            r_have  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_flush <= n_flush;
            r_have  <= n_have;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

### hw/rtl/gbe_datapath.sv
// ----------------------------------------------------------------------------
// gbe_datapath
// Configuration registers, raster counters, running left-window sum,
// left window and line store memories, OR accumulator and output register.
// ----------------------------------------------------------------------------
module gbe_datapath
    import gbe_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_HSTR   = 16,
    parameter int MAX_VSTR   = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  t_in_beat              i_in_data,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_beat             o_out_data
);

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int HSW   = $clog2(MAX_HSTR + 1);
    localparam int VW    = $clog2(MAX_VSTR + 1);
    localparam int RCW   = $clog2(MAX_VSTR + 2);
    localparam int SW    = (MAX_VSTR > 1) ? $clog2(MAX_VSTR) : 1;
    localparam int LW    = (MAX_HSTR > 1) ? $clog2(MAX_HSTR) : 1;
    localparam int DEPTH = MAX_VSTR * MAX_WIDTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int HSUMW = $clog2(MAX_HSTR * 255 + 1);

    logic [10:0]      r_cfg_w;
    logic [10:0]      r_cfg_h;
    logic [4:0]       r_cfg_hs;
    logic [3:0]       r_cfg_vs;

    logic [WW-1:0]    r_in_col, r_out_col, r_rd_col;
    logic [HW-1:0]    r_in_row, r_out_row;
    logic [SW-1:0]    r_in_slot, r_out_slot, r_rd_slot;
    logic [RCW-1:0]   r_rd_cnt;
    logic             r_rd_pend;
    logic [HSUMW-1:0] r_hsum, n_hsum;
    logic [LW-1:0]    r_lw_wptr, n_lw_wptr, lw_raddr;
    logic             r_out_valid;

    logic [PIX_W-1:0] r_pix, r_wide, r_acc, r_out_pix;
    logic             r_out_last;

    logic [WW-1:0]    eff_w;
    logic [HW-1:0]    eff_h;
    logic [HSW-1:0]   eff_hs;
    logic [VW-1:0]    eff_vs;
    logic [PIX_W-1:0] wide, lw_rdata, ln_rdata;
    logic [SW-1:0]    pix_slot;
    logic [RCW-1:0]   flush_cnt;
    logic [AW-1:0]    ln_waddr, ln_raddr;
    logic             out_last, restart, in_row_end, out_row_end;

    function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
        return (int'(s) == MAX_VSTR - 1) ? '0 : s + SW'(1);
    endfunction

    // effective register values
    always_comb begin
        if (r_cfg_w == '0) begin
            eff_w = WW'(1);
        end else if (int'(r_cfg_w) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            eff_h = HW'(1);
        end else if (int'(r_cfg_h) > MAX_HEIGHT) begin
            eff_h = HW'(MAX_HEIGHT);
        end else begin
            eff_h = HW'(r_cfg_h);
        end
        eff_hs = (int'(r_cfg_hs) > MAX_HSTR) ? HSW'(MAX_HSTR) : HSW'(r_cfg_hs);
        eff_vs = (int'(r_cfg_vs) > MAX_VSTR) ? VW'(MAX_VSTR) : VW'(r_cfg_vs);
    end

    // running window sum and saturation
    always_comb begin
        int sum_all;
        int drop;
        sum_all = int'(r_hsum) + int'(r_pix);
        drop    = 0;
        if (eff_hs != '0 && int'(r_in_col) >= int'(eff_hs)) begin
            drop = int'(lw_rdata);
        end
        wide   = (sum_all > int'(PIX_MAX)) ? PIX_MAX : PIX_W'(sum_all);
        n_hsum = (eff_hs == '0) ? '0 : HSUMW'(sum_all - drop);
    end

    // left window pointers
    always_comb begin
        if (int'(r_lw_wptr) >= int'(eff_hs)) begin
            lw_raddr = LW'(int'(r_lw_wptr) - int'(eff_hs));
        end else begin
            lw_raddr = LW'(int'(r_lw_wptr) + MAX_HSTR - int'(eff_hs));
        end
        n_lw_wptr = (int'(r_lw_wptr) == MAX_HSTR - 1) ? '0 : r_lw_wptr + LW'(1);
    end

    // read setup for a pixel beat and for a flush beat
    always_comb begin
        int rem;
        if (int'(r_in_slot) >= int'(eff_vs)) begin
            pix_slot = SW'(int'(r_in_slot) - int'(eff_vs));
        end else begin
            pix_slot = SW'(int'(r_in_slot) + MAX_VSTR - int'(eff_vs));
        end
        rem = int'(eff_h) - 1 - int'(r_out_row);
        if (int'(eff_vs) < rem) begin
            flush_cnt = RCW'(int'(eff_vs) + 1);
        end else begin
            flush_cnt = RCW'(rem + 1);
        end
    end

    assign ln_waddr = AW'(r_in_slot) * AW'(MAX_WIDTH) + AW'(r_in_col);
    assign ln_raddr = AW'(r_rd_slot) * AW'(MAX_WIDTH) + AW'(r_rd_col);

    assign in_row_end  = (r_in_col == eff_w - WW'(1));
    assign out_row_end = (r_out_col == eff_w - WW'(1));
    assign out_last    = out_row_end && (r_out_row == eff_h - HW'(1));
    assign restart     = i_cfg_we || (i_cmd.emit && out_last);

    gbe_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_HSTR)
    ) u_left_window (
        .i_clk   (i_clk),
        .i_we    (i_cmd.widen),
        .i_waddr (r_lw_wptr),
        .i_wdata (r_pix),
        .i_re    (i_cmd.start_pix),
        .i_raddr (lw_raddr),
        .o_rdata (lw_rdata)
    );

    gbe_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_line),
        .i_waddr (ln_waddr),
        .i_wdata (r_wide),
        .i_re    (i_cmd.rd_issue),
        .i_raddr (ln_raddr),
        .o_rdata (ln_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w     <= 11'd1;
            r_cfg_h     <= 11'd1;
            r_cfg_hs    <= '0;
            r_cfg_vs    <= '0;
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_in_slot   <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_out_slot  <= '0;
            r_rd_col    <= '0;
            r_rd_slot   <= '0;
            r_rd_cnt    <= '0;
            r_rd_pend   <= 1'b0;
            r_hsum      <= '0;
            r_lw_wptr   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_pend <= i_cmd.rd_issue;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.widen) begin
                r_lw_wptr <= n_lw_wptr;
                r_rd_cnt  <= RCW'(eff_vs);
                r_rd_slot <= pix_slot;
                r_rd_col  <= r_in_col;
            end
            if (i_cmd.start_flush) begin
                r_rd_cnt  <= flush_cnt;
                r_rd_slot <= r_out_slot;
                r_rd_col  <= r_out_col;
            end
            if (i_cmd.rd_issue) begin
                r_rd_cnt  <= r_rd_cnt - RCW'(1);
                r_rd_slot <= slot_inc(r_rd_slot);
            end
            if (restart) begin
                r_in_col   <= '0;
                r_in_row   <= '0;
                r_in_slot  <= '0;
                r_out_col  <= '0;
                r_out_row  <= '0;
                r_out_slot <= '0;
                r_hsum     <= '0;
            end else begin
                if (i_cmd.widen) begin
                    r_hsum <= n_hsum;
                end
                if (i_cmd.wr_line) begin
                    if (in_row_end) begin
                        r_in_col  <= '0;
                        r_in_row  <= r_in_row + HW'(1);
                        r_in_slot <= slot_inc(r_in_slot);
                        r_hsum    <= '0;
                    end else begin
                        r_in_col <= r_in_col + WW'(1);
                    end
                end
                if (i_cmd.emit) begin
                    if (out_row_end) begin
                        r_out_col  <= '0;
                        r_out_row  <= r_out_row + HW'(1);
                        r_out_slot <= slot_inc(r_out_slot);
                    end else begin
                        r_out_col <= r_out_col + WW'(1);
                    end
                end
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_IMAGE_WIDTH:    r_cfg_w  <= i_cfg_data;
                    REG_IMAGE_HEIGHT:   r_cfg_h  <= i_cfg_data;
                    REG_HORIZ_STRENGTH: r_cfg_hs <= i_cfg_data[4:0];
                    REG_VERT_STRENGTH:  r_cfg_vs <= i_cfg_data[3:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_pix) begin
            r_pix <= i_in_data.pixel_in;
        end
        if (i_cmd.widen) begin
            r_wide <= wide;
            r_acc  <= wide;
        end
        if (i_cmd.start_flush) begin
            r_acc <= '0;
        end
        if (r_rd_pend) begin
            r_acc <= r_acc | ln_rdata;
        end
        if (i_cmd.emit) begin
            r_out_pix  <= r_acc;
            r_out_last <= out_last;
        end
    end

    assign o_status.in_full  = (r_in_row >= eff_h);
    assign o_status.have     = (int'(r_in_row) >= int'(eff_vs));
    assign o_status.vs_zero  = (eff_vs == '0);
    assign o_status.rd_last  = (r_rd_cnt == RCW'(1));
    assign o_status.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid          = r_out_valid;
    assign o_out_data.pixel_out  = r_out_pix;
    assign o_out_data.frame_last = r_out_last;

endmodule

### hw/rtl/glyph_bitmap_embolden.sv
// ----------------------------------------------------------------------------
// glyph_bitmap_embolden
// Emboldens an 8-bit glyph bitmap streamed in raster order: horizontal
// saturating window sum, then a vertical OR over the rows below.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_stall   i_in_data  (t_in_beat)
//   out      output     o_out_valid / i_out_stall o_out_data (t_out_beat)
//   cfg      input      i_cfg_we                  i_cfg_idx, i_cfg_data
//
// a pixel beat is widened and written to the line store and, once the output
// rows start, handed off; with vert_strength above zero it also takes one line
// store read per row below plus a drain step; any wait for the output register
// lengthens it; a flush beat reads and ORs up to vert_strength + 1 rows, drains
// and hands off; one line store read per cycle; one beat is in work at a time
// synchronous active-low reset; the line store needs no clearing pass
// the output register lets the next beat start while a result waits
// ----------------------------------------------------------------------------
module glyph_bitmap_embolden
    import gbe_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_HSTR   = 16,
    parameter int MAX_VSTR   = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_beat              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_beat             o_out_data
);

    t_cmd    w_cmd;
    t_status w_status;

    gbe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_kind  (i_in_data.kind),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    gbe_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_HSTR   (MAX_HSTR),
        .MAX_VSTR   (MAX_VSTR)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> (!o_out_valid || !i_out_stall))
        else $error("result loaded over a beat still waiting");

    a_emit_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |=> o_out_valid)
        else $error("loaded result not presented");

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.widen || w_cmd.rd_issue || w_cmd.wr_line) |-> o_in_stall)
        else $error("input open while a beat is in work");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |=> (!o_out_data.frame_last || !w_status.in_full))
        else $error("frame not restarted after its last pixel");
`endif

endmodule
